FILE: hw/rtl/msrb_pkg.sv
package msrb_pkg;

  // request kinds
  localparam logic [1:0] REQ_LINE_RX = 2'd0;
  localparam logic [1:0] REQ_SW_READ = 2'd1;
  localparam logic [1:0] REQ_SW_PUSH = 2'd2;
  localparam logic [1:0] REQ_LINE_POP = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic       port;
    logic [7:0] data_in;
  } req_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       was_empty;
    logic [7:0] rx_count;
    logic [7:0] tx_count;
  } rsp_t;

  // operation handed to one ring bank
  typedef struct packed {
    logic       act;
    logic       wr;
    logic       rd;
    logic       port;
    logic [7:0] wdata;
  } ring_op_t;

  // status returned by a ring bank for the addressed port
  typedef struct packed {
    logic       empty;
    logic [7:0] count;
  } ring_sts_t;

endpackage

FILE: hw/rtl/msrb_ring.sv
module msrb_ring import msrb_pkg::*; #(
  parameter int NUM_PORTS = 2,
  parameter int DEPTH = 256,
  parameter bit PRE_INC = 1'b0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ring_op_t  op,
  output ring_sts_t sts,
  output logic [7:0] rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int MW = $clog2(NUM_PORTS * DEPTH);

  logic [AW-1:0] head_r [NUM_PORTS];
  logic [AW-1:0] tail_r [NUM_PORTS];
  logic [7:0]    mem_r [NUM_PORTS * DEPTH];
  logic [7:0]    rd_data_r;

  logic [PW-1:0] pidx;
  logic [AW-1:0] head, tail, head_adv, tail_adv, head_nxt, tail_nxt;
  logic          empty, do_wr, do_rd;
  logic [CW-1:0] occ;
  logic [MW-1:0] base, waddr, raddr;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
    logic [AW-1:0] q;
    q = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return q;
  endfunction

  always_comb begin
    pidx = op.act ? PW'(op.port) : '0;
    head = head_r[pidx];
    tail = tail_r[pidx];
    head_adv = advance(head);
    tail_adv = advance(tail);
    empty = (head == tail);
    do_wr = op.act & op.wr;
    do_rd = op.act & op.rd & ~empty;
    head_nxt = do_wr ? head_adv : head;
    tail_nxt = do_rd ? tail_adv : tail;
    // occupancy after the request, wrapped around the ring
    if (head_nxt >= tail_nxt) begin
      occ = CW'(head_nxt) - CW'(tail_nxt);
    end else begin
      occ = CW'(DEPTH) - CW'(tail_nxt) + CW'(head_nxt);
    end
    sts.empty = empty;
    sts.count = (32'(occ) > 32'd255) ? 8'hFF : 8'(occ);
    base = MW'(32'(pidx) * DEPTH);
    // transmit side writes and reads one slot past the pointer
    waddr = base + MW'(PRE_INC ? head_adv : head);
    raddr = base + MW'(PRE_INC ? tail_adv : tail);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      if (do_wr) begin
        head_r[pidx] <= head_nxt;
      end
      if (do_rd) begin
        tail_r[pidx] <= tail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[waddr] <= op.wdata;
    end
    if (do_rd) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/multi_port_serial_ring_buffers_top.sv
// channel   ports                      transfer
// request   start, busy, in_item       start high and busy low at a clock edge
// result    out_valid, out_item        out_valid high for one cycle, always taken
//
// one request per cycle; the result reaches the ports after passing through
// the input register, then ring pointers and memory access into the result register
// busy stays low: the rings take a request every cycle
// synchronous reset clears all ring pointers; ring memories are not cleared
// results cannot be held off, so nothing ever stalls

module multi_port_serial_ring_buffers_top import msrb_pkg::*; #(
  parameter int NUM_PORTS = 2,
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_item,
  output logic out_valid,
  output rsp_t out_item
);

  logic      req_vld_r;
  req_t      req_r;
  logic      out_vld_r;
  logic      ok_r, sel_rx_r, sel_tx_r, empty_r;
  logic [7:0] rx_cnt_r, tx_cnt_r;

  logic      port_ok;
  ring_op_t  rx_op, tx_op;
  ring_sts_t rx_sts, tx_sts;
  logic [7:0] rx_rdata, tx_rdata;
  logic      is_rx_rd, is_tx_rd, empty_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start & ~busy;
      out_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      req_r <= in_item;
    end
  end

  always_comb begin
    port_ok = (32'(req_r.port) < NUM_PORTS);
    is_rx_rd = (req_r.req_type == REQ_SW_READ);
    is_tx_rd = (req_r.req_type == REQ_LINE_POP);

    rx_op.act = req_vld_r & port_ok;
    rx_op.wr = (req_r.req_type == REQ_LINE_RX);
    rx_op.rd = is_rx_rd;
    rx_op.port = req_r.port;
    rx_op.wdata = req_r.data_in;

    tx_op.act = req_vld_r & port_ok;
    tx_op.wr = (req_r.req_type == REQ_SW_PUSH);
    tx_op.rd = is_tx_rd;
    tx_op.port = req_r.port;
    tx_op.wdata = req_r.data_in;

    empty_nxt = (is_rx_rd & rx_sts.empty) | (is_tx_rd & tx_sts.empty);
  end

  msrb_ring #(
    .NUM_PORTS(NUM_PORTS),
    .DEPTH(RX_DEPTH),
    .PRE_INC(1'b0)
  ) u_rx_ring (
    .clk(clk),
    .rst_n(rst_n),
    .op(rx_op),
    .sts(rx_sts),
    .rd_data(rx_rdata)
  );

  msrb_ring #(
    .NUM_PORTS(NUM_PORTS),
    .DEPTH(TX_DEPTH),
    .PRE_INC(1'b1)
  ) u_tx_ring (
    .clk(clk),
    .rst_n(rst_n),
    .op(tx_op),
    .sts(tx_sts),
    .rd_data(tx_rdata)
  );

  // result register, alongside the registered ring read data
  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      ok_r <= port_ok;
      sel_rx_r <= is_rx_rd & ~rx_sts.empty;
      sel_tx_r <= is_tx_rd & ~tx_sts.empty;
      empty_r <= empty_nxt;
      rx_cnt_r <= rx_sts.count;
      tx_cnt_r <= tx_sts.count;
    end
  end

  always_comb begin
    out_item = '0;
    if (ok_r) begin
      if (sel_rx_r) begin
        out_item.data_out = rx_rdata;
      end else if (sel_tx_r) begin
        out_item.data_out = tx_rdata;
      end
      out_item.was_empty = empty_r;
      out_item.rx_count = rx_cnt_r;
      out_item.tx_count = tx_cnt_r;
    end
  end

  assign out_valid = out_vld_r;

endmodule

FILE: sim/multi_port_serial_ring_buffers_top_test.sv
module multi_port_serial_ring_buffers_top_test;
  import msrb_pkg::*;

  localparam int PORTS = 2;
  localparam int STALL_LIMIT = 200;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_item;
  logic out_valid;
  rsp_t out_item;

  multi_port_serial_ring_buffers_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // mirror of the rings; depth 256, so 8-bit pointers wrap on their own
  logic [7:0] rx_ring [PORTS][256];
  logic [7:0] tx_ring [PORTS][256];
  logic [7:0] rx_wr [PORTS];
  logic [7:0] rx_rd [PORTS];
  logic [7:0] tx_wr [PORTS];
  logic [7:0] tx_rd [PORTS];

  rsp_t due_rsp [$];
  rsp_t want_rsp;
  int errors;
  int idle_cycles;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_t ring_access(req_t r);
    rsp_t res;
    int p;
    res = '0;
    p = int'(r.port);
    if (p >= PORTS) return res;
    case (r.req_type)
      REQ_LINE_RX: begin
        rx_ring[p][rx_wr[p]] = r.data_in;
        rx_wr[p] = rx_wr[p] + 8'd1;
      end
      REQ_SW_READ: begin
        if (rx_wr[p] == rx_rd[p]) begin
          res.was_empty = 1'b1;
        end else begin
          res.data_out = rx_ring[p][rx_rd[p]];
          rx_rd[p] = rx_rd[p] + 8'd1;
        end
      end
      REQ_SW_PUSH: begin
        // transmit side pre-increments before the write
        tx_wr[p] = tx_wr[p] + 8'd1;
        tx_ring[p][tx_wr[p]] = r.data_in;
      end
      default: begin
        if (tx_wr[p] == tx_rd[p]) begin
          res.was_empty = 1'b1;
        end else begin
          tx_rd[p] = tx_rd[p] + 8'd1;
          res.data_out = tx_ring[p][tx_rd[p]];
        end
      end
    endcase
    res.rx_count = rx_wr[p] - rx_rd[p];
    res.tx_count = tx_wr[p] - tx_rd[p];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // results are checked before the transfer of this edge is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (due_rsp.size() == 0) begin
          report_mismatch($sformatf("result %0h with nothing due", out_item));
        end else begin
          want_rsp = due_rsp.pop_front();
          if (out_item.data_out !== want_rsp.data_out)
            report_mismatch($sformatf("data_out expected %0h got %0h",
                                      want_rsp.data_out, out_item.data_out));
          if (out_item.was_empty !== want_rsp.was_empty)
            report_mismatch($sformatf("was_empty expected %0b got %0b",
                                      want_rsp.was_empty, out_item.was_empty));
          if (out_item.rx_count !== want_rsp.rx_count)
            report_mismatch($sformatf("rx_count expected %0d got %0d",
                                      want_rsp.rx_count, out_item.rx_count));
          if (out_item.tx_count !== want_rsp.tx_count)
            report_mismatch($sformatf("tx_count expected %0d got %0d",
                                      want_rsp.tx_count, out_item.tx_count));
        end
      end
      if (start && !busy)
        due_rsp.push_back(ring_access(in_item));
      if ((start && !busy) || out_valid)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("multi_port_serial_ring_buffers_top_test failed");
        $finish;
      end
    end
  end

  task automatic send_req(logic [1:0] kind, logic port, logic [7:0] data);
    int gap;
    req_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    r.req_type = kind;
    r.port = port;
    r.data_in = data;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      in_item <= req_t'($urandom);
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (due_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    no_gaps = 1'b0;
    send_req(REQ_SW_READ, 1'b0, 8'hFF);
    send_req(REQ_LINE_POP, 1'b0, 8'hFF);
    send_req(REQ_SW_READ, 1'b1, 8'h00);
    send_req(REQ_LINE_POP, 1'b1, 8'h00);
    send_req(REQ_LINE_RX, 1'b0, 8'h00);
    send_req(REQ_LINE_RX, 1'b0, 8'hFF);
    send_req(REQ_LINE_RX, 1'b0, 8'h55);
    send_req(REQ_LINE_RX, 1'b0, 8'hAA);
    repeat (3) send_req(REQ_SW_READ, 1'b0, 8'hFF);
    send_req(REQ_SW_PUSH, 1'b1, 8'hFF);
    send_req(REQ_SW_PUSH, 1'b1, 8'h00);
    send_req(REQ_SW_PUSH, 1'b1, 8'h81);
    repeat (4) send_req(REQ_LINE_POP, 1'b1, 8'hC3);
    send_req(REQ_LINE_RX, 1'b1, 8'h7E);
    repeat (2) send_req(REQ_SW_READ, 1'b1, 8'h3C);
  endtask

  // fill port 0 receive ring until the head lands on the tail
  task automatic test_rx_overflow();
    logic [7:0] held;
    held = rx_wr[0] - rx_rd[0];
    no_gaps = 1'($urandom_range(0, 1));
    repeat (256 - held) send_req(REQ_LINE_RX, 1'b0, 8'($urandom));
    no_gaps = 1'b0;
    send_req(REQ_SW_READ, 1'b0, 8'($urandom));
    repeat (3) send_req(REQ_LINE_RX, 1'b0, 8'($urandom));
    repeat (4) send_req(REQ_SW_READ, 1'b0, 8'($urandom));
  endtask

  task automatic test_tx_overflow();
    logic [7:0] held;
    held = tx_wr[1] - tx_rd[1];
    no_gaps = 1'($urandom_range(0, 1));
    repeat (256 - held) send_req(REQ_SW_PUSH, 1'b1, 8'($urandom));
    no_gaps = 1'b0;
    send_req(REQ_LINE_POP, 1'b1, 8'($urandom));
    repeat (4) send_req(REQ_SW_PUSH, 1'b1, 8'($urandom));
    repeat (5) send_req(REQ_LINE_POP, 1'b1, 8'($urandom));
  endtask

  // bursts that lean toward filling, draining, or an even mix
  task automatic test_random_traffic(int count);
    int sent;
    int mode;
    int len;
    int roll;
    logic main_port;
    logic [1:0] kind;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(20, 60);
      main_port = 1'($urandom_range(0, 1));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        roll = $urandom_range(0, 9);
        if (mode == 2)
          kind = 2'($urandom);
        else if ((mode == 0) == (roll < 7))
          kind = $urandom_range(0, 1) ? REQ_LINE_RX : REQ_SW_PUSH;
        else
          kind = $urandom_range(0, 1) ? REQ_SW_READ : REQ_LINE_POP;
        send_req(kind, ($urandom_range(0, 3) == 0) ? ~main_port : main_port,
                 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    errors = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    for (int p = 0; p < PORTS; p++) begin
      rx_wr[p] = '0;
      rx_rd[p] = '0;
      tx_wr[p] = '0;
      tx_rd[p] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_idle();
    test_rx_overflow();
    wait_idle();
    test_tx_overflow();
    wait_idle();
    test_random_traffic(540);
    @(negedge clk);
    start <= 1'b0;
    while (due_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("multi_port_serial_ring_buffers_top_test passed");
    end else begin
      $display("multi_port_serial_ring_buffers_top_test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/msrb_pkg.sv
hw/rtl/msrb_ring.sv
hw/rtl/multi_port_serial_ring_buffers_top.sv
sim/multi_port_serial_ring_buffers_top_test.sv
